FILE: sv/mwm_pkg.sv
package mwm_pkg;

    // table dimensions
    localparam int MAX_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 32;

    // derived widths
    localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int POS_W  = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int VEC_W  = MAX_PATTERN_LEN + 1;
    localparam int CHAR_W = 16;

    // wildcard code units
    localparam logic [CHAR_W-1:0] CH_STAR = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_ANY  = 16'h003F;

    // command codes
    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_PAT_CHAR  = 3'd1;
    localparam logic [2:0] CMD_PAT_END   = 3'd2;
    localparam logic [2:0] CMD_NAME_CHAR = 3'd3;
    localparam logic [2:0] CMD_NAME_END  = 3'd4;

    // result kinds
    localparam logic [1:0] RES_MATCH    = 2'd0;
    localparam logic [1:0] RES_STORED   = 2'd1;
    localparam logic [1:0] RES_REJECTED = 2'd2;

    typedef struct packed {
        logic [2:0]        command;
        logic [CHAR_W-1:0] char_code;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       matched;
    } out_beat_t;

    // broadcast controls from the top level to every pattern lane
    typedef struct packed {
        logic              wr_char;
        logic [POS_W-1:0]  wr_pos;
        logic              store;
        logic [LEN_W-1:0]  store_len;
        logic              restart_all;
        logic              advance;
        logic [CHAR_W-1:0] ch;
    } lane_ctl_t;

    // extend live positions across star runs: a carry chain through star bits
    function automatic logic [VEC_W-1:0] star_close(input logic [VEC_W-1:0] act,
                                                    input logic [VEC_W-1:0] star);
        logic [VEC_W:0] gen;
        logic [VEC_W:0] prop;
        logic [VEC_W:0] sum;
        logic [VEC_W:0] carry;
        gen   = {1'b0, act & star};
        prop  = {1'b0, star};
        sum   = prop + gen;
        carry = sum ^ prop ^ gen;
        return act | carry[VEC_W-1:0];
    endfunction

endpackage

FILE: sv/multi_pattern_wildcard_match_core.sv
// channel  | dir | ports                        | beat
// ---------+-----+------------------------------+---------------------------------
// input    | in  | s_valid, s_ready, s_data     | command, char_code
// result   | out | m_valid, m_ready, m_data     | result_kind, matched
//
// one beat per cycle while the result is not stalled; a result passes the input register
// and then the result register, one register on each side of the lane update
// aresetn (synchronous) empties the table and the building pattern
// a stalled result holds the input register; s_ready drops only then
module multi_pattern_wildcard_match_core
    import mwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    in_beat_t   in_reg;
    logic       in_vld_reg;
    logic       fire;
    logic       m_valid_reg;
    out_beat_t  m_data_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] blen_reg, blen_next;
    logic             bovf_reg, bovf_next;

    lane_ctl_t         ctl;
    logic              res_vld;
    out_beat_t         res;
    logic [MAX_PATTERNS-1:0] hits;
    logic [MAX_PATTERNS-1:0] used;

    assign fire    = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // command decode and table bookkeeping
    always_comb begin
        count_next      = count_reg;
        blen_next       = blen_reg;
        bovf_next       = bovf_reg;
        ctl             = '0;
        ctl.wr_pos      = blen_reg[POS_W-1:0];
        ctl.store_len   = blen_reg;
        ctl.ch          = in_reg.char_code;
        res_vld         = 1'b0;
        res             = '0;
        if (fire) begin
            unique case (in_reg.command)
                CMD_CLEAR: begin
                    count_next      = '0;
                    blen_next       = '0;
                    bovf_next       = 1'b0;
                    ctl.restart_all = 1'b1;
                end
                CMD_PAT_CHAR: begin
                    if (blen_reg < LEN_W'(MAX_PATTERN_LEN)) begin
                        ctl.wr_char = (count_reg < CNT_W'(MAX_PATTERNS));
                        blen_next   = blen_reg + LEN_W'(1);
                    end else begin
                        bovf_next = 1'b1;
                    end
                end
                CMD_PAT_END: begin
                    res_vld = 1'b1;
                    if (blen_reg != '0 && !bovf_reg && count_reg < CNT_W'(MAX_PATTERNS)) begin
                        ctl.store       = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res.result_kind = RES_STORED;
                    end else begin
                        res.result_kind = RES_REJECTED;
                    end
                    blen_next = '0;
                    bovf_next = 1'b0;
                end
                CMD_NAME_CHAR: begin
                    ctl.advance = 1'b1;
                end
                CMD_NAME_END: begin
                    res_vld         = 1'b1;
                    res.result_kind = RES_MATCH;
                    res.matched     = |(hits & used);
                    ctl.restart_all = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            blen_reg  <= '0;
            bovf_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            blen_reg  <= blen_next;
            bovf_reg  <= bovf_next;
        end
    end

    // one lane per pattern slot
    for (genvar k = 0; k < MAX_PATTERNS; k++) begin : g_lane
        assign used[k] = CNT_W'(k) < count_reg;
        mwm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sel     (count_reg == CNT_W'(k)),
            .hit     (hits[k])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res_vld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_vld) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_PATTERNS))
        else $error("pattern count beyond table size");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        bovf_reg |-> blen_reg == LEN_W'(MAX_PATTERN_LEN))
        else $error("overflow flag without a full pattern");

    a_pat_unmatched: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind != RES_MATCH |-> !m_data.matched)
        else $error("pattern result carries a match flag");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && m_valid_reg && !m_ready |-> !s_ready)
        else $error("input taken while result stage is stalled");

endmodule

FILE: sv/mwm_lane.sv
module mwm_lane
    import mwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lane_ctl_t ctl,
    input  logic      sel,
    output logic      hit
);

    logic [CHAR_W-1:0] chars_reg [MAX_PATTERN_LEN];
    logic [LEN_W-1:0]  len_reg;
    logic [VEC_W-1:0]  act_reg;
    logic [VEC_W-1:0]  act_next;
    logic [LEN_W-1:0]  eff_len;
    logic [VEC_W-1:0]  star_v;
    logic [VEC_W-1:0]  step_v;
    logic              load;

    assign load    = ctl.store && sel;
    assign eff_len = load ? ctl.store_len : len_reg;

    // per-position star and single-step flags, limited to the pattern length
    always_comb begin
        star_v = '0;
        step_v = '0;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (LEN_W'(i) < eff_len) begin
                star_v[i] = (chars_reg[i] == CH_STAR);
                step_v[i] = (chars_reg[i] == CH_ANY) || (chars_reg[i] == ctl.ch);
            end
        end
    end

    // live position update
    always_comb begin
        act_next = act_reg;
        if (ctl.restart_all || load) begin
            act_next = star_close(VEC_W'(1), star_v);
        end else if (ctl.advance) begin
            act_next = star_close((act_reg & star_v) | ((act_reg & step_v) << 1), star_v);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= VEC_W'(1);
        end else begin
            act_reg <= act_next;
        end
    end

    // pattern storage
    always_ff @(posedge aclk) begin
        if (ctl.wr_char && sel) begin
            chars_reg[ctl.wr_pos] <= ctl.ch;
        end
        if (load) begin
            len_reg <= ctl.store_len;
        end
    end

    assign hit = act_reg[len_reg];

endmodule
